### hdl/ebf_pkg.sv
// Package for the enclosing brace block finder.
// Holds the sizing constants, brace codes and the request, result and stack-op types.
// No dependencies; every other file in hdl/ imports it.
package ebf_pkg;

  // Sizing of the open-brace stack and of the byte position counter
  localparam int STACK_DEPTH   = 64;
  localparam int POSITION_BITS = 24;
  localparam int PosW          = POSITION_BITS + 1;
  localparam int CountW        = $clog2(STACK_DEPTH + 1);

  localparam logic [CountW-1:0] DepthCount = CountW'(STACK_DEPTH);
  localparam logic [PosW-1:0]   PosLimit   = PosW'(1) << POSITION_BITS;

  // Brace characters
  localparam logic [7:0] OPEN_CH  = 8'h7B;
  localparam logic [7:0] CLOSE_CH = 8'h7D;

  // One text byte request
  typedef struct packed {
    logic [7:0] text_byte;
    logic       protected_byte;
    logic       last_byte;
  } req_t;

  // One scan result
  typedef struct packed {
    logic                     block_found;
    logic [POSITION_BITS-1:0] block_start;
    logic [PosW-1:0]          block_end;
    logic                     overflow;
  } res_t;

  // Stack operation broadcast to every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

endpackage

### hdl/enclosing_brace_block_finder.sv
// Enclosing brace block finder: one text byte per cycle, back to back.
// A byte is handled in the cycle it is accepted; the result of the last byte
// sits in the output register from the next cycle until it is taken.
// The stack is a chain of STACK_DEPTH cells, pushed and popped at cell 0 only.
// Reset clears the cursor register and all scan state but the stack cells at once; no clearing pass.
// Input stalls only for a last byte while an earlier result is held and its output is stalled.
module enclosing_brace_block_finder (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ebf_pkg::PosW-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  ebf_pkg::req_t           in_req_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output ebf_pkg::res_t           out_res_o
);
  import ebf_pkg::*;

  logic [PosW-1:0]          cursor_q;
  logic [PosW-1:0]          pos_q, pos_d;
  logic [CountW-1:0]        count_q, count_d;
  logic                     seen_q, seen_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [PosW-1:0]          end_q, end_d;
  logic                     ovf_q, ovf_d;
  logic                     out_valid_q, out_valid_d;
  res_t                     out_res_q;

  // Values after this byte, before the end-of-text clear
  logic [PosW-1:0]          pos_n;
  logic [CountW-1:0]        count_n;
  logic                     seen_n;
  logic [POSITION_BITS-1:0] start_n;
  logic [PosW-1:0]          end_n;
  logic                     ovf_n;

  logic                     in_acc;
  logic                     is_open;
  logic                     is_close;
  logic [PosW-1:0]          pos_inc;
  logic [POSITION_BITS-1:0] top;
  stack_op_t                op;
  res_t                     res;

  logic [POSITION_BITS-1:0] cell_data [STACK_DEPTH];

  // Handshake: a last byte waits while the held result cannot leave
  assign in_stall_o = out_valid_q & out_stall_i & in_req_i.last_byte;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign is_open  = ~in_req_i.protected_byte & (in_req_i.text_byte == OPEN_CH);
  assign is_close = ~in_req_i.protected_byte & (in_req_i.text_byte == CLOSE_CH);
  assign pos_inc  = pos_q + PosW'(1);
  assign top      = cell_data[0];

  // Cursor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else if (cfg_we_i) begin
      cursor_q <= cfg_wdata_i;
    end
  end

  // Scan step: advance position, push or pop, record a matching pair around the cursor, flag overflow
  always_comb begin
    pos_n   = pos_q;
    count_n = count_q;
    seen_n  = seen_q;
    start_n = start_q;
    end_n   = end_q;
    ovf_n   = ovf_q;
    op      = '0;
    if (in_acc) begin
      if (pos_q[POSITION_BITS]) begin
        ovf_n = 1'b1;
      end else begin
        pos_n = pos_inc;
        if (is_open) begin
          if (count_q != DepthCount) begin
            op.push = 1'b1;
            count_n = count_q + CountW'(1);
          end else begin
            ovf_n = 1'b1;
          end
        end else if (is_close && (count_q != '0)) begin
          op.pop  = 1'b1;
          count_n = count_q - CountW'(1);
          if ((PosW'(top) <= cursor_q) && (cursor_q <= pos_inc)) begin
            seen_n  = 1'b1;
            start_n = top;
            end_n   = pos_inc;
          end
        end
      end
    end
  end

  // Result of the text as it stands after this byte
  always_comb begin
    res.block_found = seen_n & ~ovf_n;
    res.block_start = res.block_found ? start_n : '0;
    res.block_end   = res.block_found ? end_n : '0;
    res.overflow    = ovf_n;
  end

  // Clear the scan state after the last byte
  always_comb begin
    if (in_acc && in_req_i.last_byte) begin
      pos_d   = '0;
      count_d = '0;
      seen_d  = 1'b0;
      start_d = '0;
      end_d   = '0;
      ovf_d   = 1'b0;
    end else begin
      pos_d   = pos_n;
      count_d = count_n;
      seen_d  = seen_n;
      start_d = start_n;
      end_d   = end_n;
      ovf_d   = ovf_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      count_q <= '0;
      seen_q  <= 1'b0;
      start_q <= '0;
      end_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      count_q <= count_d;
      seen_q  <= seen_d;
      start_q <= start_d;
      end_q   <= end_d;
      ovf_q   <= ovf_d;
    end
  end

  // Stack: chain of cells, top of stack in cell 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [POSITION_BITS-1:0] above;
    logic [POSITION_BITS-1:0] below;
    if (i == 0) begin : g_first
      assign above = pos_q[POSITION_BITS-1:0];
    end else begin : g_mid
      assign above = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = cell_data[i];
    end else begin : g_inner
      assign below = cell_data[i+1];
    end
    ebf_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .above_i (above),
      .below_i (below),
      .data_o  (cell_data[i])
    );
  end

  // Output register: load on the last byte, drop once taken
  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (in_acc && in_req_i.last_byte) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_req_i.last_byte) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCount)
    else $error("stack count above depth");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLimit)
    else $error("byte position above limit");

  a_found_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_res_o.block_found && out_res_o.overflow))
    else $error("found reported together with overflow");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_req_i.last_byte) |=>
      (out_valid_q && (pos_q == '0) && (count_q == '0) && !ovf_q && !seen_q))
    else $error("scan state not cleared after last byte");
`endif

endmodule

### hdl/ebf_cell.sv
// One cell of the shifting open-brace stack.
// Holds one brace position; takes it from the cell above on a push and from
// the cell below on a pop. Depends on ebf_pkg.
module ebf_cell (
  input  logic                             clk_i,
  input  ebf_pkg::stack_op_t               op_i,
  input  logic [ebf_pkg::POSITION_BITS-1:0] above_i,
  input  logic [ebf_pkg::POSITION_BITS-1:0] below_i,
  output logic [ebf_pkg::POSITION_BITS-1:0] data_o
);
  import ebf_pkg::*;

  logic [POSITION_BITS-1:0] data_q;

  // Shift down on push, up on pop, hold otherwise
  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      data_q <= above_i;
    end else if (op_i.pop) begin
      data_q <= below_i;
    end
  end

  assign data_o = data_q;

endmodule
